// ===== hdl/tlbf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tlbf_pkg;

  // Table geometry
  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Field widths
  localparam int PAGE_W  = 20;
  localparam int FRAME_W = 20;
  localparam int SLOT_W  = 3;
  localparam int CNT_W   = 32;

  // Stream word widths
  localparam int IN_BITS  = PAGE_W + FRAME_W + 1;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 2 + SLOT_W + FRAME_W + 2 * CNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Replacement policy codes
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  // Lookup results rippling along the row of entries
  typedef struct packed {
    logic               found;
    idx_t               hit_idx;
    logic [FRAME_W-1:0] hit_frame;
    idx_t               hit_rank;
    logic               lru_seen;
    idx_t               lru_idx;
  } chain_t;

  // Update broadcast to every entry
  typedef struct packed {
    logic               fill;
    idx_t               fill_idx;
    logic               touch;
    idx_t               touch_idx;
    idx_t               touch_rank;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } upd_t;

endpackage

`default_nettype wire

// ===== hdl/tlbf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlbf_cell (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire tlbf_pkg::idx_t          cell_idx,
  input  wire logic [tlbf_pkg::PAGE_W-1:0] look_page,
  input  wire tlbf_pkg::chain_t        chain_i,
  output tlbf_pkg::chain_t             chain_o,
  input  wire tlbf_pkg::upd_t          upd_i
);
  import tlbf_pkg::*;

  logic [PAGE_W-1:0]  tag_r;
  logic [FRAME_W-1:0] frame_r;
  logic               valid_r, valid_nxt;
  idx_t               rank_r, rank_nxt;
  logic               match;

  // Compare and pass the first match and the oldest entry on down the row
  always_comb begin
    match   = valid_r && (tag_r == look_page);
    chain_o = chain_i;
    if (!chain_i.found && match) begin
      chain_o.found     = 1'b1;
      chain_o.hit_idx   = cell_idx;
      chain_o.hit_frame = frame_r;
      chain_o.hit_rank  = rank_r;
    end
    if (!chain_i.lru_seen && (rank_r == '0)) begin
      chain_o.lru_seen = 1'b1;
      chain_o.lru_idx  = cell_idx;
    end
  end

  // Work out valid and recency updates
  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    if (upd_i.fill && (upd_i.fill_idx == cell_idx)) begin
      valid_nxt = 1'b1;
    end
    if (upd_i.touch) begin
      if (upd_i.touch_idx == cell_idx) begin
        rank_nxt = IDX_W'(ENTRIES - 1);
      end else if (rank_r > upd_i.touch_rank) begin
        rank_nxt = rank_r - IDX_W'(1);
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= cell_idx;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  // Write tag and frame on a fill
  always_ff @(posedge clk) begin
    if (upd_i.fill && (upd_i.fill_idx == cell_idx)) begin
      tag_r   <= upd_i.page;
      frame_r <= upd_i.frame;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tlb_fifo_lru_fill.sv =====
// The result word for an accepted input word is registered and appears in the next cycle.
// Throughput: one word per cycle; the lookup ripples through the row of entry
// cells and the update is written back in the same cycle.
// A waiting result does not block the next word when out_tready is high.
// Reset (rst_n low, synchronous): entries invalid, ranks equal to index,
// FIFO pointer, counters and policy zero; tags and frames are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module tlb_fifo_lru_fill (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_wdata,     // replace_policy
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // [19:0] virtual_page, [39:20] frame_number, [40] translation_valid, rest zero
  input  wire logic [tlbf_pkg::IN_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // [0] hit, [1] filled, [4:2] slot, [24:5] held_frame,
  // [56:25] hit_total, [88:57] access_total, rest zero
  output logic [tlbf_pkg::OUT_W-1:0]     out_tdata
);
  import tlbf_pkg::*;

  logic                 policy_r;
  idx_t                 ptr_r, ptr_nxt;
  logic [CNT_W-1:0]     hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]     acc_cnt_r, acc_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r;
  logic [OUT_W-1:0]     out_data_nxt;

  logic                 accept;
  logic [PAGE_W-1:0]    in_page;
  logic [FRAME_W-1:0]   in_frame;
  logic                 in_ok;
  logic                 lru;
  logic                 hit;
  logic                 miss;
  idx_t                 victim;
  logic [IDX_W:0]       ptr_inc;
  logic [SLOT_W-1:0]    slot;
  logic [FRAME_W-1:0]   held;
  upd_t                 upd;
  chain_t               chain [0:ENTRIES];

  assign in_page  = in_tdata[PAGE_W-1:0];
  assign in_frame = in_tdata[PAGE_W+FRAME_W-1:PAGE_W];
  assign in_ok    = in_tdata[PAGE_W+FRAME_W];

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Row of entry cells
  assign chain[0] = '0;
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tlbf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(i)),
      .look_page (in_page),
      .chain_i   (chain[i]),
      .chain_o   (chain[i+1]),
      .upd_i     (upd)
    );
  end

  // Pick victim and build the update word
  always_comb begin
    lru     = (policy_r == POLICY_LRU);
    hit     = in_ok && chain[ENTRIES].found;
    miss    = in_ok && !chain[ENTRIES].found;
    victim  = lru ? chain[ENTRIES].lru_idx : ptr_r;
    ptr_inc = {1'b0, ptr_r} + (IDX_W + 1)'(1);

    upd.fill       = accept && miss;
    upd.fill_idx   = victim;
    upd.touch      = accept && lru && in_ok;
    upd.touch_idx  = hit ? chain[ENTRIES].hit_idx : chain[ENTRIES].lru_idx;
    upd.touch_rank = hit ? chain[ENTRIES].hit_rank : '0;
    upd.page       = in_page;
    upd.frame      = in_frame;

    ptr_nxt = ptr_r;
    if (accept && miss && !lru) begin
      ptr_nxt = (ptr_inc == (IDX_W + 1)'(ENTRIES)) ? '0 : ptr_inc[IDX_W-1:0];
    end

    slot = '0;
    held = '0;
    if (hit) begin
      slot = SLOT_W'(chain[ENTRIES].hit_idx);
      held = chain[ENTRIES].hit_frame;
    end else if (miss) begin
      slot = SLOT_W'(victim);
      held = in_frame;
    end
  end

  // Advance saturating counters and load the result word
  always_comb begin
    hit_cnt_nxt   = hit_cnt_r;
    acc_cnt_nxt   = acc_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (accept) begin
      if (acc_cnt_r != '1) begin
        acc_cnt_nxt = acc_cnt_r + CNT_W'(1);
      end
      if (hit && (hit_cnt_r != '1)) begin
        hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
      end
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_W'({acc_cnt_nxt, hit_cnt_nxt, held, slot, miss, hit});
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POLICY_FIFO;
      ptr_r       <= '0;
      hit_cnt_r   <= '0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
      ptr_r       <= ptr_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  // Ranks always form a permutation, so some entry holds the oldest rank
  a_lru_exists: assert property (@(posedge clk) disable iff (!rst_n)
    chain[ENTRIES].lru_seen)
    else $error("no entry holds the least recent rank");

  // A result never reports both a hit and a fill
  a_hit_fill_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[0] && out_data_r[1]))
    else $error("hit and fill reported together");

  // Hits never outnumber accesses
  a_hits_le_acc: assert property (@(posedge clk) disable iff (!rst_n)
    hit_cnt_r <= acc_cnt_r)
    else $error("hit counter exceeds access counter");

  // A FIFO fill moves the pointer, nothing else does
  a_ptr_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && miss && !lru) |=> $stable(ptr_r))
    else $error("fifo pointer moved without a fifo fill");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_tlb_fifo_lru_fill.sv =====
`timescale 1ns / 1ps

module tb_tlb_fifo_lru_fill;
  import tlbf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 230;

  // One result word, declared high field first so that hit lands in bit 0
  typedef struct packed {
    logic [CNT_W-1:0]   access_total;
    logic [CNT_W-1:0]   hit_total;
    logic [FRAME_W-1:0] held_frame;
    logic [SLOT_W-1:0]  slot;
    logic               filled;
    logic               hit;
  } lookup_result_t;

  // Shadow TLB: predicts each lookup and checks result words in order
  class tlb_scoreboard;
    logic [PAGE_W-1:0]  tags   [ENTRIES];
    logic [FRAME_W-1:0] frames [ENTRIES];
    logic               live   [ENTRIES];
    idx_t               rank   [ENTRIES];
    idx_t               fifo_ptr;
    logic               policy;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   accesses;
    lookup_result_t     expected_q[$];
    int                 failures;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        live[i] = 1'b0;
        rank[i] = idx_t'(i);
      end
      fifo_ptr = '0;
      policy   = POLICY_FIFO;
      hits     = '0;
      accesses = '0;
      failures = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Move an entry to the most recent rank, closing the gap it leaves
    function void promote(int e);
      idx_t old;
      old = rank[e];
      for (int i = 0; i < ENTRIES; i++)
        if (rank[i] > old) rank[i]--;
      rank[e] = idx_t'(ENTRIES - 1);
    endfunction

    // Predict the lookup for an accepted input word
    function void note_access(logic [PAGE_W-1:0] page, logic [FRAME_W-1:0] frame, logic ok);
      lookup_result_t r;
      int found;
      int victim;
      r = '0;
      if (accesses != '1) accesses++;
      if (ok) begin
        found = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (found < 0 && live[i] && tags[i] == page) found = i;
        if (found >= 0) begin
          if (hits != '1) hits++;
          if (policy == POLICY_LRU) promote(found);
          r.hit        = 1'b1;
          r.slot       = SLOT_W'(found);
          r.held_frame = frames[found];
        end else begin
          victim = 0;
          if (policy == POLICY_LRU) begin
            for (int i = ENTRIES - 1; i >= 0; i--)
              if (rank[i] == '0) victim = i;
          end else begin
            victim   = int'(fifo_ptr);
            fifo_ptr = (victim == ENTRIES - 1) ? '0 : idx_t'(victim + 1);
          end
          tags[victim]   = page;
          frames[victim] = frame;
          live[victim]   = 1'b1;
          if (policy == POLICY_LRU) promote(victim);
          r.filled     = 1'b1;
          r.slot       = SLOT_W'(victim);
          r.held_frame = frame;
        end
      end
      r.hit_total    = hits;
      r.access_total = accesses;
      expected_q.push_back(r);
    endfunction

    function void flag(string what, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
      failures++;
      if (failures <= 10)
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endfunction

    // Compare a result word field by field with the oldest prediction
    function void check_result(logic [OUT_W-1:0] word);
      lookup_result_t got;
      lookup_result_t want;
      got = lookup_result_t'(word[OUT_BITS-1:0]);
      if (expected_q.size() == 0) begin
        flag("unexpected result word", '0, word);
        return;
      end
      want = expected_q.pop_front();
      if (got.hit !== want.hit) flag("hit", want.hit, got.hit);
      if (got.filled !== want.filled) flag("filled", want.filled, got.filled);
      if (got.slot !== want.slot) flag("slot", want.slot, got.slot);
      if (got.held_frame !== want.held_frame)
        flag("held_frame", want.held_frame, got.held_frame);
      if (got.hit_total !== want.hit_total) flag("hit_total", want.hit_total, got.hit_total);
      if (got.access_total !== want.access_total)
        flag("access_total", want.access_total, got.access_total);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_wdata = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  tlb_scoreboard sb = new();

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_req  = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int cycles = 0;

  tlb_fifo_lru_fill dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: long hold-off on request, otherwise random stalls
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap(1'b0);
    end
  end

  // Check every result word taken by the receiver
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Offer one access word after a random gap and hold it until taken
  task automatic send_access(input logic [PAGE_W-1:0] page, input logic [FRAME_W-1:0] frame,
                             input logic ok);
    logic [IN_W-1:0] word;
    int gap;
    word = '0;
    word[PAGE_W-1:0] = page;
    word[PAGE_W+FRAME_W-1:PAGE_W] = frame;
    word[PAGE_W+FRAME_W] = ok;
    gap = pick_gap(tx_steady);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    sb.note_access(page, frame, ok);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_policy(input logic p);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    sb.policy = p;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [PAGE_W-1:0] pool [16];
    logic [PAGE_W-1:0] page;
    int pool_n;
    int r;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: fill in FIFO order, hits, invalid words, pointer wrap
    write_policy(POLICY_FIFO);
    send_access(20'hFFFFF, 20'hFFFFF, 1'b0);
    send_access(20'h00000, 20'hFFFFF, 1'b1);
    send_access(20'hFFFFF, 20'h00000, 1'b1);
    for (int i = 2; i < ENTRIES; i++)
      send_access(20'h5A5A0 + PAGE_W'(i), 20'hA5A50 + FRAME_W'(i), 1'b1);
    send_access(20'h00000, 20'h12345, 1'b1);
    send_access(20'hFFFFF, 20'hFFFFF, 1'b0);
    send_access(20'hAAAAA, 20'h55555, 1'b1);

    // Directed: switch to LRU on the same table, reorder and evict
    write_policy(POLICY_LRU);
    send_access(20'hFFFFF, 20'h0F0F0, 1'b1);
    send_access(20'h5A5A2, 20'h00001, 1'b1);
    send_access(20'h55555, 20'hAAAAA, 1'b1);
    send_access(20'h0F0F0, 20'hF0F0F, 1'b1);
    send_access(20'hFFFFF, 20'h00000, 1'b1);

    // Directed: back to FIFO, the pointer resumes where it stopped
    write_policy(POLICY_FIFO);
    send_access(20'h33333, 20'hCCCCC, 1'b1);
    send_access(20'hFFFFF, 20'h80000, 1'b1);

    // Random phases over a small page pool so that hits and evictions mix
    for (int phase = 0; phase < PHASES; phase++) begin
      write_policy(phase % 2 == 0 ? POLICY_LRU : POLICY_FIFO);
      rx_steady = (phase == 5);
      pool_n = $urandom_range(ENTRIES - 3, ENTRIES + 6);
      for (int k = 0; k < pool_n; k++) pool[k] = PAGE_W'($urandom());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) tx_steady = (phase == 3) || ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        page = (r < 85) ? pool[$urandom_range(0, pool_n - 1)] : PAGE_W'($urandom());
        send_access(page, FRAME_W'($urandom()), r < 95);
        // Hold the receiver off while words keep coming
        if (phase == 2 && n == 5) hold_req = 1'b1;
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.failures == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
